// ----- src/bsn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorting network package
// Shared types, direction codes and the elaboration-time schedule builder
// that places every compare-exchange of the network into a pipeline layer.
// ----------------------------------------------------------------------------
package bsn_pkg;

    localparam int MAX_ELEMS = 8;
    localparam int IDX_W     = 3;
    localparam int STACK_D   = 32;

    // Direction of one compare-exchange.
    localparam logic [1:0] MODE_FOLLOW = 2'd0;
    localparam logic [1:0] MODE_ASC    = 2'd1;
    localparam logic [1:0] MODE_DESC   = 2'd2;

    localparam int KIND_SORT  = 0;
    localparam int KIND_MERGE = 1;

    typedef struct packed {
        logic valid;
        logic up;
    } t_ctl;

    typedef struct packed {
        logic [4:0]                            layers;
        logic [MAX_ELEMS-1:0]                  active;
        logic [MAX_ELEMS-1:0]                  is_a;
        logic [MAX_ELEMS-1:0][IDX_W-1:0]       partner;
        logic [MAX_ELEMS-1:0][1:0]             mode;
    } t_map;

    // Walks the recursive sort in order, gives each compare-exchange the
    // earliest layer after the previous ones on its two positions, and
    // returns the placement of the requested layer.
    function automatic t_map walk(input int n, input int sel);
        t_map       m;
        int         sp;
        int         kind [STACK_D];
        int         lo   [STACK_D];
        int         cnt  [STACK_D];
        logic [1:0] md   [STACK_D];
        int         nf   [MAX_ELEMS];
        int         k;
        int         l;
        int         c;
        int         h;
        logic [1:0] md_c;
        int         i;
        int         a;
        int         b;
        int         ly;
        int         steps;
        m = '0;
        for (i = 0; i < MAX_ELEMS; i++) begin
            nf[i] = 0;
        end
        sp      = 1;
        kind[0] = KIND_SORT;
        lo[0]   = 0;
        cnt[0]  = n;
        md[0]   = MODE_FOLLOW;
        for (steps = 0; steps < 512 && sp > 0; steps++) begin
            sp   = sp - 1;
            k    = kind[sp];
            l    = lo[sp];
            c    = cnt[sp];
            md_c = md[sp];
            if (c > 1) begin
                h = c >> 1;
                if (k == KIND_SORT) begin
                    kind[sp] = KIND_MERGE; lo[sp] = l;     cnt[sp] = c; md[sp] = md_c;
                    sp = sp + 1;
                    kind[sp] = KIND_SORT;  lo[sp] = l + h; cnt[sp] = h; md[sp] = MODE_DESC;
                    sp = sp + 1;
                    kind[sp] = KIND_SORT;  lo[sp] = l;     cnt[sp] = h; md[sp] = MODE_ASC;
                    sp = sp + 1;
                end else begin
                    for (i = 0; i < h; i++) begin
                        a  = l + i;
                        b  = a + h;
                        ly = (nf[a] > nf[b]) ? nf[a] : nf[b];
                        nf[a] = ly + 1;
                        nf[b] = ly + 1;
                        if (ly + 1 > int'(m.layers)) begin
                            m.layers = 5'(ly + 1);
                        end
                        if (ly == sel) begin
                            m.active[a]  = 1'b1;
                            m.active[b]  = 1'b1;
                            m.is_a[a]    = 1'b1;
                            m.partner[a] = IDX_W'(b);
                            m.partner[b] = IDX_W'(a);
                            m.mode[a]    = md_c;
                            m.mode[b]    = md_c;
                        end
                    end
                    kind[sp] = KIND_MERGE; lo[sp] = l + h; cnt[sp] = h; md[sp] = md_c;
                    sp = sp + 1;
                    kind[sp] = KIND_MERGE; lo[sp] = l;     cnt[sp] = h; md[sp] = md_c;
                    sp = sp + 1;
                end
            end
        end
        return m;
    endfunction

    function automatic int num_layers(input int n);
        t_map m;
        m = walk(n, 0);
        return int'(m.layers);
    endfunction

endpackage

// ----- src/bsn_cmp_exch.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorting network compare-exchange cell
// Orders one pair of signed elements in the requested direction.
// ----------------------------------------------------------------------------
module bsn_cmp_exch #(
    parameter int DATA_WIDTH = 32
) (
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    input  logic                  i_up,
    output logic [DATA_WIDTH-1:0] o_a,
    output logic [DATA_WIDTH-1:0] o_b
);

    logic w_greater;
    logic w_swap;

    assign w_greater = $signed(i_a) > $signed(i_b);
    assign w_swap    = (i_up == w_greater);
    assign o_a       = w_swap ? i_b : i_a;
    assign o_b       = w_swap ? i_a : i_b;

endmodule

// ----- src/bsn_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorting network layer
// One registered layer of compare-exchange cells working side by side.
// ----------------------------------------------------------------------------
module bsn_stage #(
    parameter int ELEMENT_COUNT = 8,
    parameter int DATA_WIDTH    = 32,
    parameter int STAGE         = 0
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_adv,
    input  bsn_pkg::t_ctl                             i_ctl,
    input  logic [ELEMENT_COUNT-1:0][DATA_WIDTH-1:0]  i_data,
    output bsn_pkg::t_ctl                             o_ctl,
    output logic [ELEMENT_COUNT-1:0][DATA_WIDTH-1:0]  o_data
);

    localparam bsn_pkg::t_map MAP = bsn_pkg::walk(ELEMENT_COUNT, STAGE);

    wire  [ELEMENT_COUNT-1:0][DATA_WIDTH-1:0] w_next;
    wire  [ELEMENT_COUNT-1:0]                 w_up;
    bsn_pkg::t_ctl                            r_ctl;
    logic [ELEMENT_COUNT-1:0][DATA_WIDTH-1:0] r_data;

    for (genvar p = 0; p < ELEMENT_COUNT; p++) begin : g_pos
        if (MAP.active[p] && MAP.is_a[p]) begin : g_cell
            localparam int Q = int'(MAP.partner[p]);
            assign w_up[p] = (MAP.mode[p] == bsn_pkg::MODE_ASC)  ? 1'b1 :
                             (MAP.mode[p] == bsn_pkg::MODE_DESC) ? 1'b0 : i_ctl.up;
            bsn_cmp_exch #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .i_a (i_data[p]),
                .i_b (i_data[Q]),
                .i_up(w_up[p]),
                .o_a (w_next[p]),
                .o_b (w_next[Q])
            );
        end else if (MAP.active[p]) begin : g_b_side
            assign w_up[p] = i_ctl.up;
        end else begin : g_pass
            assign w_up[p]   = i_ctl.up;
            assign w_next[p] = i_data[p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= w_next;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_data = r_data;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_data) && $stable(r_ctl))
        else $error("Layer contents changed while the pipeline was stalled.");

    for (genvar p = 0; p < ELEMENT_COUNT; p++) begin : g_chk
        if (MAP.active[p] && MAP.is_a[p]) begin : g_pair
            localparam int Q = int'(MAP.partner[p]);
            a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                i_adv && i_ctl.valid |=>
                    ($past(w_up[p]) ? ($signed(r_data[p]) <= $signed(r_data[Q]))
                                    : ($signed(r_data[p]) >= $signed(r_data[Q]))))
                else $error("Compare-exchange left a pair out of order.");
        end
    end

endmodule

// ----- src/bitonic_sorting_network_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorting network
// Sorts the signed elements of each beat, ascending or descending.
// ----------------------------------------------------------------------------
// Channel      Direction  Contents
// s_axis       in         ELEMENT_COUNT unsorted elements per beat
// m_axis       out        the same elements, sorted
// cfg          in         direction register: 1 ascending, 0 descending
//
// Each beat passes through one registered layer per network layer, and one
// beat is accepted per cycle while the output beat is not held.
// When the output beat is held, every layer freezes and s_axis is not ready.
// Reset empties the layers and selects ascending order.
// ----------------------------------------------------------------------------
module bitonic_sorting_network_top #(
    parameter int ELEMENT_COUNT = 8,
    parameter int DATA_WIDTH    = 32
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_s_axis_tvalid,
    output logic                                           o_s_axis_tready,
    // elem_0 .. elem_(ELEMENT_COUNT-1), from the lowest bits
    input  logic [((ELEMENT_COUNT*DATA_WIDTH+7)/8)*8-1:0]  i_s_axis_tdata,
    output logic                                           o_m_axis_tvalid,
    input  logic                                           i_m_axis_tready,
    // sorted_0 .. sorted_(ELEMENT_COUNT-1), from the lowest bits
    output logic [((ELEMENT_COUNT*DATA_WIDTH+7)/8)*8-1:0]  o_m_axis_tdata,
    input  logic                                           i_cfg_wr_en,
    input  logic                                           i_cfg_wr_data
);

    localparam int ELEMS_W    = ELEMENT_COUNT * DATA_WIDTH;
    localparam int TDATA_W    = ((ELEMS_W + 7) / 8) * 8;
    localparam int NUM_STAGES = bsn_pkg::num_layers(ELEMENT_COUNT);

    wire  [NUM_STAGES:0][ELEMENT_COUNT-1:0][DATA_WIDTH-1:0] w_data;
    wire  bsn_pkg::t_ctl [NUM_STAGES:0]                     w_ctl;
    logic                                                   w_adv;
    logic                                                   r_ascending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascending <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_ascending <= i_cfg_wr_data;
        end
    end

    assign w_adv     = !w_ctl[NUM_STAGES].valid || i_m_axis_tready;
    assign w_data[0] = i_s_axis_tdata[ELEMS_W-1:0];
    assign w_ctl[0]  = '{valid: i_s_axis_tvalid, up: r_ascending};

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        bsn_stage #(
            .ELEMENT_COUNT(ELEMENT_COUNT),
            .DATA_WIDTH   (DATA_WIDTH),
            .STAGE        (s)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_ctl  (w_ctl[s]),
            .i_data (w_data[s]),
            .o_ctl  (w_ctl[s+1]),
            .o_data (w_data[s+1])
        );
    end

    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = w_ctl[NUM_STAGES].valid;
    assign o_m_axis_tdata  = TDATA_W'(w_data[NUM_STAGES]);

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("Input beat accepted while the output beat was held.");

    a_held_beat_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("Held output beat changed before it was taken.");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output beat valid straight after reset.");

endmodule
